// ===== design/spre_pkg.sv =====
// Shared constants, types and state codes of the shortest-path relaxation engine.
package spre_pkg;

    localparam int NODE_W     = 6;
    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 512;
    localparam int EDGE_AW    = 9;
    localparam int CNT_W      = 10;
    localparam int WT_W       = 11;
    localparam int EDGE_W     = 2 * NODE_W + WT_W;
    localparam int DIST_W     = 24;
    localparam int SUM_W      = DIST_W + 1;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [NODE_W-1:0] TOP_RESET = NODE_W'(MAX_NODES - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(1) <<< (DIST_W - 1));
    localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) <<< (DIST_W - 1)) - SUM_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_BAD
    } t_state;

    // one edge presented to the distance unit, alongside its edge-store read
    typedef struct packed {
        logic                     issue;
        logic                     check;
        logic                     in_range;
        logic [NODE_W-1:0]        src;
        logic [NODE_W-1:0]        dst;
        logic signed [WT_W-1:0]   wt;
    } t_relax_req;

    typedef struct packed {
        logic busy;
        logic sat;
        logic relaxed;
    } t_relax_stat;

endpackage

// ===== design/shortest_path_relaxation_engine_unit.sv =====
// Bellman-Ford engine: edge loading, relaxation sequencing and result output.
// While idle, edges load at one transfer per cycle into a 512-entry edge store.
// After the last edge, a run makes highest_node + 1 passes over the stored edges, the last a check
// (one edge per cycle through the distance memory's read-modify-write loop).
// Results then leave one at a time, paced by the distance memory read and held while the output stalls.
// Reset (synchronous, active low) empties the edge store, sets highest_node to 63.
module shortest_path_relaxation_engine_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spre_pkg::NODE_W-1:0]          i_cfg_data,    // highest_node
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [spre_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // edge_source, edge_target, edge_weight
    input  logic                                 s_axis_tlast,  // last_edge
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [spre_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // node_index, node_distance
    output logic                                 m_axis_tuser,  // feasible
    output logic                                 m_axis_tlast   // last_result
);

    localparam int NW = spre_pkg::NODE_W;

    logic [spre_pkg::EDGE_W-1:0] r_edges [spre_pkg::MAX_EDGES];
    logic [spre_pkg::EDGE_W-1:0] r_erd;

    spre_pkg::t_state             r_state, n_state;
    logic [NW-1:0]                r_top;
    logic [spre_pkg::CNT_W-1:0]   r_count, n_count;
    logic [spre_pkg::EDGE_AW-1:0] r_eidx, n_eidx;
    logic [NW-1:0]                r_round, n_round;
    logic [NW-1:0]                r_oidx, n_oidx;
    logic                         r_s1_valid;
    logic                         r_s1_check;

    logic                               r_m_valid, n_m_valid;
    logic [spre_pkg::OUT_TDATA_W-1:0]   r_m_data, n_m_data;
    logic                               r_m_user, n_m_user;
    logic                               r_m_last, n_m_last;

    logic                               clear;
    logic                               issue;
    logic                               slot_free;
    logic                               in_xfer;
    logic                               last_edge_idx;
    spre_pkg::t_relax_req               req;
    spre_pkg::t_relax_stat              stat;
    logic signed [spre_pkg::DIST_W-1:0] rd_dist;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_m_valid || m_axis_tready;
    assign last_edge_idx = (spre_pkg::CNT_W'(r_eidx) + spre_pkg::CNT_W'(1)) == r_count;

    always_ff @(posedge i_clk) begin
        if (in_xfer && r_count < spre_pkg::CNT_W'(spre_pkg::MAX_EDGES)) begin
            r_edges[r_count[spre_pkg::EDGE_AW-1:0]] <= s_axis_tdata[spre_pkg::EDGE_W-1:0];
        end
        r_erd      <= r_edges[r_eidx];
        r_s1_check <= (r_round == r_top);
    end

    always_comb begin
        req.issue    = r_s1_valid;
        req.check    = r_s1_check;
        req.src      = r_erd[NW-1:0];
        req.dst      = r_erd[2*NW-1:NW];
        req.wt       = r_erd[spre_pkg::EDGE_W-1:2*NW];
        req.in_range = (req.src <= r_top) && (req.dst <= r_top);
    end

    spre_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clear),
        .i_req     (req),
        .i_rd_addr (r_oidx),
        .o_rd_dist (rd_dist),
        .o_stat    (stat)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_eidx    = r_eidx;
        n_round   = r_round;
        n_oidx    = r_oidx;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;
        n_m_valid = r_m_valid && !m_axis_tready;
        clear     = 1'b0;
        issue     = 1'b0;
        case (r_state)
            spre_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_count < spre_pkg::CNT_W'(spre_pkg::MAX_EDGES)) begin
                        n_count = r_count + spre_pkg::CNT_W'(1);
                    end
                    if (s_axis_tlast) begin
                        clear   = 1'b1;
                        n_eidx  = '0;
                        n_round = '0;
                        n_state = spre_pkg::ST_RUN;
                    end
                end
            end
            spre_pkg::ST_RUN: begin
                issue = 1'b1;
                if (last_edge_idx) begin
                    n_eidx = '0;
                    if (r_round == r_top) begin
                        n_state = spre_pkg::ST_DRAIN;
                    end else begin
                        n_round = r_round + NW'(1);
                    end
                end else begin
                    n_eidx = r_eidx + spre_pkg::EDGE_AW'(1);
                end
            end
            spre_pkg::ST_DRAIN: begin
                if (!r_s1_valid && !stat.busy) begin
                    n_count = '0;
                    n_oidx  = '0;
                    n_state = (stat.sat || stat.relaxed) ? spre_pkg::ST_OUT_BAD
                                                         : spre_pkg::ST_OUT_RD;
                end
            end
            spre_pkg::ST_OUT_RD: begin
                n_state = spre_pkg::ST_OUT_LD;
            end
            spre_pkg::ST_OUT_LD: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{(spre_pkg::OUT_TDATA_W - spre_pkg::DIST_W - NW){1'b0}},
                                 rd_dist, r_oidx};
                    n_m_user  = 1'b1;
                    n_m_last  = (r_oidx == r_top);
                    if (r_oidx == r_top) begin
                        n_state = spre_pkg::ST_IDLE;
                    end else begin
                        n_oidx  = r_oidx + NW'(1);
                        n_state = spre_pkg::ST_OUT_RD;
                    end
                end
            end
            spre_pkg::ST_OUT_BAD: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = '0;
                    n_m_user  = 1'b0;
                    n_m_last  = 1'b1;
                    n_state   = spre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_eidx   <= n_eidx;
        r_round  <= n_round;
        r_oidx   <= n_oidx;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spre_pkg::ST_IDLE;
            r_top      <= spre_pkg::TOP_RESET;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_s1_valid <= issue;
            r_m_valid  <= n_m_valid;
            if (i_cfg_valid) begin
                r_top <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == spre_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spre_pkg::CNT_W'(spre_pkg::MAX_EDGES))
        else $error("edge count beyond store depth");

    a_no_issue_outside_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != spre_pkg::ST_RUN) |=> !r_s1_valid)
        else $error("edge issued outside a relaxation run");

    a_drained_before_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spre_pkg::ST_OUT_RD || r_state == spre_pkg::ST_OUT_BAD)
            |-> (!r_s1_valid && !stat.busy))
        else $error("result phase entered with relaxation in flight");

    a_infeasible_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("infeasible result not marked last");

endmodule

// ===== design/spre_dist.sv =====
// Distance memory with read-modify-write relaxation, forwarding and run flags.
module spre_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  spre_pkg::t_relax_req              i_req,
    input  logic [spre_pkg::NODE_W-1:0]       i_rd_addr,
    output logic signed [spre_pkg::DIST_W-1:0] o_rd_dist,
    output spre_pkg::t_relax_stat             o_stat
);

    logic signed [spre_pkg::DIST_W-1:0] r_mem [spre_pkg::MAX_NODES];
    logic [spre_pkg::MAX_NODES-1:0]     r_dval;

    logic signed [spre_pkg::DIST_W-1:0] r_rd_a;
    logic signed [spre_pkg::DIST_W-1:0] r_rd_b;
    logic                               r_rd_a_ok;
    logic                               r_rd_b_ok;

    logic                               r_s2_valid;
    logic                               r_s2_check;
    logic                               r_s2_in_range;
    logic [spre_pkg::NODE_W-1:0]        r_s2_src;
    logic [spre_pkg::NODE_W-1:0]        r_s2_dst;
    logic signed [spre_pkg::WT_W-1:0]   r_s2_wt;

    logic                               r_fw_en;
    logic [spre_pkg::NODE_W-1:0]        r_fw_addr;
    logic signed [spre_pkg::DIST_W-1:0] r_fw_data;

    logic                               r_sat;
    logic                               r_relaxed;

    logic [spre_pkg::NODE_W-1:0]        addr_a;
    logic signed [spre_pkg::DIST_W-1:0] du;
    logic signed [spre_pkg::DIST_W-1:0] dv;
    logic signed [spre_pkg::SUM_W-1:0]  sum;
    logic signed [spre_pkg::DIST_W-1:0] cand;
    logic                               under;
    logic                               act;
    logic                               better;
    logic                               we;

    assign addr_a = i_req.issue ? i_req.src : i_rd_addr;

    always_ff @(posedge i_clk) begin
        r_rd_a    <= r_mem[addr_a];
        r_rd_b    <= r_mem[i_req.dst];
        r_rd_a_ok <= r_dval[addr_a];
        r_rd_b_ok <= r_dval[i_req.dst];
        if (we) begin
            r_mem[r_s2_dst] <= cand;
        end
    end

    // the write of the previous edge is not yet visible to the registered reads
    always_comb begin
        if (r_fw_en && r_fw_addr == r_s2_src) begin
            du = r_fw_data;
        end else begin
            du = r_rd_a_ok ? r_rd_a : '0;
        end
        if (r_fw_en && r_fw_addr == r_s2_dst) begin
            dv = r_fw_data;
        end else begin
            dv = r_rd_b_ok ? r_rd_b : '0;
        end
        sum   = {du[spre_pkg::DIST_W-1], du}
              + {{(spre_pkg::SUM_W - spre_pkg::WT_W){r_s2_wt[spre_pkg::WT_W-1]}}, r_s2_wt};
        under = sum < spre_pkg::SUM_MIN;
        if (under) begin
            cand = spre_pkg::SUM_MIN[spre_pkg::DIST_W-1:0];
        end else if (sum > spre_pkg::SUM_MAX) begin
            cand = spre_pkg::SUM_MAX[spre_pkg::DIST_W-1:0];
        end else begin
            cand = sum[spre_pkg::DIST_W-1:0];
        end
        act    = r_s2_valid && r_s2_in_range;
        better = cand < dv;
        we     = act && !r_s2_check && better;
    end

    always_ff @(posedge i_clk) begin
        r_s2_check    <= i_req.check;
        r_s2_in_range <= i_req.in_range;
        r_s2_src      <= i_req.src;
        r_s2_dst      <= i_req.dst;
        r_s2_wt       <= i_req.wt;
        r_fw_addr     <= r_s2_dst;
        r_fw_data     <= cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dval     <= '0;
            r_s2_valid <= 1'b0;
            r_fw_en    <= 1'b0;
            r_sat      <= 1'b0;
            r_relaxed  <= 1'b0;
        end else begin
            r_s2_valid <= i_req.issue;
            r_fw_en    <= we;
            if (i_clear) begin
                r_dval    <= '0;
                r_sat     <= 1'b0;
                r_relaxed <= 1'b0;
            end else begin
                if (we) begin
                    r_dval[r_s2_dst] <= 1'b1;
                end
                if (act && under) begin
                    r_sat <= 1'b1;
                end
                if (act && r_s2_check && better) begin
                    r_relaxed <= 1'b1;
                end
            end
        end
    end

    assign o_rd_dist      = r_rd_a_ok ? r_rd_a : '0;
    assign o_stat.busy    = r_s2_valid;
    assign o_stat.sat     = r_sat;
    assign o_stat.relaxed = r_relaxed;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the shortest-path relaxation engine: edge streams in, distances out.
module testbench;

    localparam int CLK_PERIOD    = 12;
    localparam int RAND_ARCS     = 75;
    localparam int QUIET_FROM    = 60;
    localparam int SAT_ARCS      = 135;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 3000;
    localparam int DIST_LO       = -(1 << (spre_pkg::DIST_W - 1));
    localparam int DIST_HI       = (1 << (spre_pkg::DIST_W - 1)) - 1;

    typedef struct {
        logic [spre_pkg::NODE_W-1:0]      src;
        logic [spre_pkg::NODE_W-1:0]      dst;
        logic signed [spre_pkg::WT_W-1:0] wt;
    } t_arc;

    typedef struct {
        logic [spre_pkg::NODE_W-1:0]        node;
        logic signed [spre_pkg::DIST_W-1:0] dist_v;
        logic                               feas;
        logic                               last;
    } t_node_result;

    class spre_scoreboard;
        t_arc         arcs[$];
        t_node_result expected_dists[$];
        int unsigned  top_node = spre_pkg::MAX_NODES - 1;
        int           errors = 0;
        int           node_dist[spre_pkg::MAX_NODES];
        bit           sat_seen;

        function void set_top(int unsigned v);
            top_node = v;
        endfunction

        function int unsigned pending();
            return expected_dists.size();
        endfunction

        function int add_sat(int a, int b);
            int s;
            s = a + b;
            if (s < DIST_LO) begin
                sat_seen = 1;
                s = DIST_LO;
            end
            if (s > DIST_HI)
                s = DIST_HI;
            return s;
        endfunction

        function bit relax_pass(bit apply);
            bit relaxed;
            int u;
            int v;
            int cand;
            relaxed = 0;
            foreach (arcs[i]) begin
                u = arcs[i].src;
                v = arcs[i].dst;
                // arcs touching nodes beyond the configured range sit out
                if (u > int'(top_node) || v > int'(top_node))
                    continue;
                cand = add_sat(node_dist[u], int'(arcs[i].wt));
                if (cand < node_dist[v]) begin
                    relaxed = 1;
                    if (apply)
                        node_dist[v] = cand;
                end
            end
            return relaxed;
        endfunction

        function void solve_graph();
            bit           bad;
            t_node_result r;
            foreach (node_dist[i])
                node_dist[i] = 0;
            sat_seen = 0;
            for (int k = 0; k < int'(top_node); k++)
                void'(relax_pass(1));
            bad = relax_pass(0);
            bad = bad || sat_seen;
            if (bad) begin
                r.node   = '0;
                r.dist_v = '0;
                r.feas   = 1'b0;
                r.last   = 1'b1;
                expected_dists.insert(expected_dists.size(), r);
            end else begin
                for (int i = 0; i <= int'(top_node); i++) begin
                    r.node   = spre_pkg::NODE_W'(i);
                    r.dist_v = spre_pkg::DIST_W'(node_dist[i]);
                    r.feas   = 1'b1;
                    r.last   = (i == int'(top_node));
                    expected_dists.insert(expected_dists.size(), r);
                end
            end
        endfunction

        function void note_arc(t_arc a, bit last);
            // a full store drops the arc, but a final one still starts the run
            if (arcs.size() < spre_pkg::MAX_EDGES)
                arcs.insert(arcs.size(), a);
            if (last) begin
                solve_graph();
                arcs.delete();
            end
        endfunction

        function void check_result(t_node_result got);
            t_node_result want;
            if (expected_dists.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, node %0d distance %0d feasible %0b",
                         $time, got.node, got.dist_v, got.feas);
                return;
            end
            want = expected_dists.pop_front();
            if (got.node !== want.node) begin
                errors++;
                $display("%0t: node_index expected %0d actual %0d", $time, want.node, got.node);
            end
            if (got.dist_v !== want.dist_v) begin
                errors++;
                $display("%0t: node_distance expected %0d actual %0d (node %0d)",
                         $time, want.dist_v, got.dist_v, want.node);
            end
            if (got.feas !== want.feas) begin
                errors++;
                $display("%0t: feasible expected %0b actual %0b", $time, want.feas, got.feas);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last_result expected %0b actual %0b", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [spre_pkg::NODE_W-1:0]      i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [spre_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [spre_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    logic hold_off = 1'b0;
    bit   idle_on = 1'b1;
    bit   pressure_go = 1'b0;
    int   arcs_sent = 0;

    spre_scoreboard sb = new;

    shortest_path_relaxation_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic send_arc(input int s, input int d, input int w, input bit last);
        t_arc a;
        a.src = spre_pkg::NODE_W'(s);
        a.dst = spre_pkg::NODE_W'(d);
        a.wt  = spre_pkg::WT_W'(w);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, a.wt, a.dst, a.src};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_arc(a, last);
        arcs_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_top(input int v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= spre_pkg::NODE_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_top(v);
    endtask

    task automatic rand_graph();
        int top;
        int kind;
        int n;
        int s;
        int d;
        int w;
        bit wide;
        top  = sb.top_node;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 10);
        if (kind == 9) begin
            // planted two-arc loop with negative total weight
            s = $urandom_range(0, top);
            d = $urandom_range(0, top);
            w = $urandom_range(0, 900);
            send_arc(s, d, w, 1'b0);
            send_arc(d, s, -w - $urandom_range(1, 100), 1'b0);
        end
        for (int i = 0; i < n; i++) begin
            wide = ($urandom_range(0, 9) == 0);
            if (kind <= 5 && !wide) begin
                // forward arcs only: these arcs alone form no cycle
                s = $urandom_range(0, top - 1);
                d = $urandom_range(s + 1, top);
                w = $urandom_range(0, 2047) - 1024;
            end else begin
                s = wide ? $urandom_range(0, spre_pkg::MAX_NODES - 1) : $urandom_range(0, top);
                d = wide ? $urandom_range(0, spre_pkg::MAX_NODES - 1) : $urandom_range(0, top);
                if (kind <= 7 && $urandom_range(0, 2) != 0)
                    w = $urandom_range(0, 1023);
                else
                    w = $urandom_range(0, 2047) - 1024;
            end
            send_arc(s, d, w, i == n - 1);
        end
    endtask

    // sink side: checks each transfer, then picks next cycle's tready
    initial begin
        int           stall;
        t_node_result got;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.node   = m_axis_tdata[spre_pkg::NODE_W-1:0];
                got.dist_v = m_axis_tdata[spre_pkg::NODE_W +: spre_pkg::DIST_W];
                got.feas   = m_axis_tuser;
                got.last   = m_axis_tlast;
                sb.check_result(got);
            end
            if (stall > 0)
                stall--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 4);
            m_axis_tready <= !(hold_off || stall > 0);
        end
    end

    // long back-pressure so the engine fills and holds off the edge stream
    initial begin
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int graph_no;
        int rand_start;
        int pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting, all 64 nodes
        send_arc(63, 0, -1024, 1'b1);
        send_arc(0, 63, 1023, 1'b0);
        send_arc(5, 5, 0, 1'b0);
        send_arc(1, 2, -1, 1'b1);
        send_arc(3, 4, -5, 1'b0);
        send_arc(4, 3, 2, 1'b1);
        send_arc(7, 7, -1, 1'b1);

        // single node, no rounds
        write_top(0);
        send_arc(0, 1, -5, 1'b1);
        send_arc(0, 0, -1, 1'b1);

        write_top(1);
        send_arc(5, 6, -3, 1'b1);
        send_arc(0, 1, -1024, 1'b0);
        send_arc(1, 0, 1023, 1'b1);
        send_arc(1, 0, -7, 1'b1);

        // long run of negative self-loops drives the sum past the saturation floor
        write_top(63);
        repeat (SAT_ARCS - 1) send_arc(0, 0, -1024, 1'b0);
        send_arc(0, 0, -1024, 1'b1);

        graph_no   = 0;
        rand_start = arcs_sent;
        while (arcs_sent - rand_start < RAND_ARCS) begin
            if (graph_no % 3 == 0) begin
                if (graph_no == 0)
                    pick = spre_pkg::MAX_NODES - 1;
                else if ($urandom_range(0, 3) == 0)
                    pick = $urandom_range(0, 1) ? 1 : spre_pkg::MAX_NODES - 1;
                else
                    pick = $urandom_range(1, spre_pkg::MAX_NODES - 1);
                write_top(pick);
                pressure_go = 1'b1;
            end
            if (arcs_sent - rand_start >= QUIET_FROM)
                idle_on = 1'b0;
            rand_graph();
            graph_no++;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/spre_pkg.sv
design/spre_dist.sv
design/shortest_path_relaxation_engine_unit.sv
tb/sv/testbench.sv
